### rtl/koct_pkg.sv
// ----------------------------------------------------------------------------
// koct_pkg
// Shared types and constants of the key occurrence count table.
// ----------------------------------------------------------------------------
package koct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 48;
  localparam int COUNT_BITS  = 32;
  localparam int SLOT_BITS   = 6;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);

  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FETCH,
    ST_UPDATE
  } koct_state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic fetch;
    logic commit;
  } koct_cmd_t;

endpackage

### rtl/koct_ram.sv
// ----------------------------------------------------------------------------
// koct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module koct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/koct_ctrl.sv
// ----------------------------------------------------------------------------
// koct_ctrl
// Sequencer: accept, match, fetch, update; owns the item handshakes.
// ----------------------------------------------------------------------------
module koct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output koct_pkg::koct_cmd_t cmd
);
  import koct_pkg::*;

  koct_state_t state, state_next;
  logic        out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MATCH;
      ST_MATCH:  state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MATCH:  cmd.match  = 1'b1;
      ST_FETCH:  cmd.fetch  = 1'b1;
      ST_UPDATE: cmd.commit = out_free;
      default:   cmd        = '0;
    endcase
    out_valid_next = cmd.commit | (out_valid & out_stall);
  end

`ifndef ASSERT_OFF
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("pending result lost");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall)
    else $error("input open while busy");

  a_update_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && out_valid && out_stall |=> state == ST_UPDATE)
    else $error("update left while result pending");
`endif

endmodule

### rtl/koct_dp.sv
// ----------------------------------------------------------------------------
// koct_dp
// Key cells with parallel compare, key and count RAMs, fill level, result
// register.
// ----------------------------------------------------------------------------
module koct_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  koct_pkg::koct_cmd_t             cmd,
  input  logic                            action,
  input  logic [koct_pkg::KEY_BITS-1:0]   key,
  input  logic [koct_pkg::SLOT_BITS-1:0]  slot,
  output logic                            hit,
  output logic                            inserted,
  output logic                            dropped_full,
  output logic [koct_pkg::SLOT_BITS-1:0]  entry_slot,
  output logic [koct_pkg::KEY_BITS-1:0]   entry_key,
  output logic [koct_pkg::COUNT_BITS-1:0] entry_count,
  output logic                            entry_valid,
  output logic [koct_pkg::FILL_BITS-1:0]  used_entries
);
  import koct_pkg::*;

  logic                  action_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [SLOT_BITS-1:0]  slot_q;

  logic [KEY_BITS-1:0]   cell_key [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_vld;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic                  hit_q;
  logic [ADDR_BITS-1:0]  idx_q;
  logic [ADDR_BITS-1:0]  enc_idx;
  logic [FILL_BITS-1:0]  fill_level;
  logic [ADDR_BITS-1:0]  fill_lo;
  logic                  full;

  logic                  is_read;
  logic                  do_hit;
  logic                  do_ins;
  logic                  do_drop;
  logic                  slot_ok;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [KEY_BITS-1:0]   kram_rd;
  logic [COUNT_BITS-1:0] cram_rd;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  cram_we;
  logic [ADDR_BITS-1:0]  cram_waddr;
  logic [COUNT_BITS-1:0] cram_wdata;

  assign fill_lo = fill_level[ADDR_BITS-1:0];
  assign full    = (fill_level == FILL_BITS'(TABLE_DEPTH));
  assign is_read = (action_q == ACT_READ);
  assign slot_ok = ({{(FILL_BITS-SLOT_BITS){1'b0}}, slot_q} < fill_level);
  assign do_hit  = !is_read && hit_q;
  assign do_ins  = !is_read && !hit_q && !full;
  assign do_drop = !is_read && !hit_q && full;
  assign cnt_inc = (cram_rd == {COUNT_BITS{1'b1}}) ? cram_rd : cram_rd + COUNT_BITS'(1);

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      key_q    <= key;
      slot_q   <= slot;
    end
  end

  // key cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.commit && do_ins && fill_lo == ADDR_BITS'(i)) begin
        cell_key[i] <= key_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld  <= '0;
      fill_level <= '0;
    end else if (cmd.commit && do_ins) begin
      entry_vld[fill_lo] <= 1'b1;
      fill_level         <= fill_level + FILL_BITS'(1);
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      match_vec <= '0;
    end else if (cmd.match) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match_vec[i] <= entry_vld[i] && (cell_key[i] == key_q);
      end
    end
  end

  // keys are unique, so at most one match bit is set
  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      enc_idx = enc_idx | (match_vec[i] ? ADDR_BITS'(i) : '0);
    end
  end

  assign rd_addr = is_read ? slot_q[ADDR_BITS-1:0] : enc_idx;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      hit_q <= |match_vec;
      idx_q <= enc_idx;
    end
  end

  assign cram_we    = cmd.commit && (do_hit || do_ins);
  assign cram_waddr = do_hit ? idx_q : fill_lo;
  assign cram_wdata = do_hit ? cnt_inc : COUNT_BITS'(1);

  koct_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit && do_ins),
    .waddr (fill_lo),
    .wdata (key_q),
    .re    (cmd.fetch),
    .raddr (rd_addr),
    .rdata (kram_rd)
  );

  koct_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cram_waddr),
    .wdata (cram_wdata),
    .re    (cmd.fetch),
    .raddr (rd_addr),
    .rdata (cram_rd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= do_hit;
      inserted     <= do_ins;
      dropped_full <= do_drop;
      if (is_read) begin
        entry_slot   <= slot_q;
        entry_key    <= slot_ok ? kram_rd : '0;
        entry_count  <= slot_ok ? cram_rd : '0;
        entry_valid  <= slot_ok;
        used_entries <= fill_level;
      end else if (do_hit) begin
        entry_slot   <= SLOT_BITS'(idx_q);
        entry_key    <= key_q;
        entry_count  <= cnt_inc;
        entry_valid  <= 1'b1;
        used_entries <= fill_level;
      end else if (do_ins) begin
        entry_slot   <= SLOT_BITS'(fill_lo);
        entry_key    <= key_q;
        entry_count  <= COUNT_BITS'(1);
        entry_valid  <= 1'b1;
        used_entries <= fill_level + FILL_BITS'(1);
      end else begin
        entry_slot   <= '0;
        entry_key    <= '0;
        entry_count  <= '0;
        entry_valid  <= 1'b0;
        used_entries <= fill_level;
      end
    end
  end

`ifndef ASSERT_OFF
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("key stored twice");

  a_vld_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_vld) == 32'(fill_level))
    else $error("valid bits disagree with fill level");

  a_fill_only_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(fill_level))
    else $error("fill level moved outside commit");
`endif

endmodule

### rtl/key_occurrence_count_table.sv
// ----------------------------------------------------------------------------
// key_occurrence_count_table
// Per-key occurrence counter with insertion-ordered readout.
// ----------------------------------------------------------------------------
// One item is handled at a time. The accepting edge captures it; it then
// passes a parallel compare of the key against all stored key cells, a read
// of the key and count RAMs, and the count update with write-back, after
// which its result sits in the output register. A new item is taken in the
// cycle after the update, also while the previous result still waits on
// out_stall; the update stage holds only while an older result is still
// undelivered.
// Observe items count keys, saturating at all ones; new keys are appended in
// first-seen order until the table is full, then dropped and flagged. Read
// items return the entry at a slot. No clearing pass is needed after reset.
module key_occurrence_count_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [koct_pkg::KEY_BITS-1:0]   key,
  input  logic [koct_pkg::SLOT_BITS-1:0]  slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic                            inserted,
  output logic                            dropped_full,
  output logic [koct_pkg::SLOT_BITS-1:0]  entry_slot,
  output logic [koct_pkg::KEY_BITS-1:0]   entry_key,
  output logic [koct_pkg::COUNT_BITS-1:0] entry_count,
  output logic                            entry_valid,
  output logic [koct_pkg::FILL_BITS-1:0]  used_entries
);
  import koct_pkg::*;

  koct_cmd_t cmd;

  koct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  koct_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .key          (key),
    .slot         (slot),
    .hit          (hit),
    .inserted     (inserted),
    .dropped_full (dropped_full),
    .entry_slot   (entry_slot),
    .entry_key    (entry_key),
    .entry_count  (entry_count),
    .entry_valid  (entry_valid),
    .used_entries (used_entries)
  );

endmodule
